// File: sv/joint_transform_and_subspace_assert.svh
// Assertion macros for the joint transform block.
`ifndef JOINT_TRANSFORM_AND_SUBSPACE_ASSERT_SVH
`define JOINT_TRANSFORM_AND_SUBSPACE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/jts_pkg.sv
// Shared types and constants of the joint transform block.
`default_nettype none

package jts_pkg;

  typedef enum logic [2:0] {
    JT_PRISM_X   = 3'd0,
    JT_PRISM_Y   = 3'd1,
    JT_PRISM_Z   = 3'd2,
    JT_INVALID   = 3'd3,
    JT_REV_X     = 3'd4,
    JT_REV_Y     = 3'd5,
    JT_REV_Z     = 3'd6,
    JT_REV_X_ALT = 3'd7
  } jt_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Decoded joint kind, travels with each request.
  typedef struct packed {
    logic  revolute;
    axis_e axis;
    logic  invalid;
  } cls_t;

  // Rows of the 6x6 transform.
  localparam logic [2:0] FIRST_ROW = 3'd0;
  localparam logic [2:0] ROW_RX    = 3'd3;
  localparam logic [2:0] ROW_RY    = 3'd4;
  localparam logic [2:0] ROW_RZ    = 3'd5;
  localparam logic [2:0] LAST_ROW  = ROW_RZ;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Internal angle / CORDIC format: Q30 with headroom up to 4*pi.
  localparam int unsigned Q30_FRAC = 30;
  localparam int unsigned Q30_W    = 35;
  localparam int unsigned ATAN_N   = 32;

  localparam logic [63:0] TWOPI_Q60 = 64'h6487ED5110B4611A;

  localparam logic signed [Q30_W-1:0] TWOPI30     = Q30_W'(64'h1921FB544);
  localparam logic signed [Q30_W-1:0] PI30        = Q30_W'(64'hC90FDAA2);
  localparam logic signed [Q30_W-1:0] HALF30      = Q30_W'(64'h6487ED51);
  localparam logic signed [Q30_W-1:0] CORDIC_GAIN = Q30_W'(64'h26DD3B6A);

  // atan(2^-i), truncated, Q30
  localparam logic signed [Q30_W-1:0] ATAN_Q30 [ATAN_N] = '{
    Q30_W'(32'h3243F6A8), Q30_W'(32'h1DAC6705), Q30_W'(32'h0FADBAFC), Q30_W'(32'h07F56EA6),
    Q30_W'(32'h03FEAB76), Q30_W'(32'h01FFD55B), Q30_W'(32'h00FFFAAA), Q30_W'(32'h007FFF55),
    Q30_W'(32'h003FFFEA), Q30_W'(32'h001FFFFD), Q30_W'(32'h000FFFFF), Q30_W'(32'h0007FFFF),
    Q30_W'(32'h0003FFFF), Q30_W'(32'h0001FFFF), Q30_W'(32'h0000FFFF), Q30_W'(32'h00007FFF),
    Q30_W'(32'h00003FFF), Q30_W'(32'h00001FFF), Q30_W'(32'h00000FFF), Q30_W'(32'h000007FF),
    Q30_W'(32'h000003FF), Q30_W'(32'h000001FF), Q30_W'(32'h000000FF), Q30_W'(32'h0000007F),
    Q30_W'(32'h0000003F), Q30_W'(32'h0000001F), Q30_W'(32'h0000000F), Q30_W'(32'h00000007),
    Q30_W'(32'h00000003), Q30_W'(32'h00000001), Q30_W'(32'h00000000), Q30_W'(32'h00000000)
  };

endpackage

`default_nettype wire

// File: sv/jts_if.sv
// Request and result channel interfaces of the joint transform block.
`default_nettype none

interface jts_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   joint_type;
  logic signed [DATA_WIDTH-1:0] position;

  modport source (output valid, output joint_type, output position, input ready);
  modport sink   (input valid, input joint_type, input position, output ready);
endinterface

interface jts_out_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   row_index;
  logic signed [DATA_WIDTH-1:0] element_0;
  logic signed [DATA_WIDTH-1:0] element_1;
  logic signed [DATA_WIDTH-1:0] element_2;
  logic signed [DATA_WIDTH-1:0] element_3;
  logic signed [DATA_WIDTH-1:0] element_4;
  logic signed [DATA_WIDTH-1:0] element_5;
  logic                         subspace_element;
  logic                         invalid_type;
  logic                         last_row;

  modport source (
    output valid, output row_index,
    output element_0, output element_1, output element_2,
    output element_3, output element_4, output element_5,
    output subspace_element, output invalid_type, output last_row,
    input ready
  );
  modport sink (
    input valid, input row_index,
    input element_0, input element_1, input element_2,
    input element_3, input element_4, input element_5,
    input subspace_element, input invalid_type, input last_row,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/joint_transform_and_subspace.sv
// Top level of the spatial joint transform and motion subspace block.
//
//   channel | dir | payload                                          | per request
//   --------+-----+--------------------------------------------------+------------
//   in_i    | in  | joint_type, position                             | 1 request
//   out_o   | out | row_index, element_0..5, subspace_element,       | 6 results
//           |     | invalid_type, last_row                           |
//
// Request rate is set by the six row results that leave on out_o from the row
// sequencer, one per cycle while out_o.ready is high.
// From acceptance to row 0 a request passes the front register, the queue, the
// magnitude stage, MS reduction steps of the angle modulo 2*pi (13 at the
// default widths), the Q30 conversion, wrap and fold stages, NIT =
// min(CORDIC_ITERATIONS, 32) CORDIC stages, rounding stages and row register.
// Reset is asynchronous and clears only valid bits, pointers and counters.
// A stall on out_o freezes the arithmetic pipeline only once its last stage
// holds a finished request; queue and front register keep in_i open until full.
// Prismatic requests run through the same pipeline and ignore its sine/cosine.
`default_nettype none

`include "joint_transform_and_subspace_assert.svh"

module joint_transform_and_subspace #(
  parameter int unsigned DATA_WIDTH        = 32,
  parameter int unsigned FRAC_BITS         = 16,
  parameter int unsigned CORDIC_ITERATIONS = 18
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  jts_in_if.sink    in_i,
  jts_out_if.source out_o
);

  localparam int unsigned QW = $bits(jts_pkg::cls_t) + DATA_WIDTH;

  // front end to queue
  logic                         fr_push;
  jts_pkg::cls_t                fr_cls;
  logic signed [DATA_WIDTH-1:0] fr_pos;
  logic                         q_full, q_empty, q_pop;
  logic [QW-1:0]                q_data;

  // pipeline to row sequencer
  logic                         pipe_en;
  logic                         sc_valid;
  jts_pkg::cls_t                sc_cls;
  logic signed [DATA_WIDTH-1:0] sc_pos, sc_cos, sc_sin, sc_nsin;
  logic                         rows_take;

  jts_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (fr_push),
    .cls_o  (fr_cls),
    .pos_o  (fr_pos)
  );

  jts_fifo #(
    .WIDTH (QW),
    .DEPTH (jts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  ({fr_cls, fr_pos}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  // The whole pipeline advances together; it holds only while its last
  // stage carries a request the row sequencer cannot take yet.
  assign pipe_en = !sc_valid || rows_take;
  assign q_pop   = pipe_en && !q_empty;

  jts_sincos #(
    .DATA_WIDTH        (DATA_WIDTH),
    .FRAC_BITS         (FRAC_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_sincos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (!q_empty),
    .in_cls_i    (jts_pkg::cls_t'(q_data[QW-1:DATA_WIDTH])),
    .in_pos_i    (q_data[DATA_WIDTH-1:0]),
    .out_valid_o (sc_valid),
    .out_cls_o   (sc_cls),
    .out_pos_o   (sc_pos),
    .cos_o       (sc_cos),
    .sin_o       (sc_sin),
    .nsin_o      (sc_nsin)
  );

  jts_rows #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rows (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sc_valid),
    .take_o     (rows_take),
    .in_cls_i   (sc_cls),
    .in_pos_i   (sc_pos),
    .cos_i      (sc_cos),
    .sin_i      (sc_sin),
    .nsin_i     (sc_nsin),
    .out_o      (out_o)
  );

  // Rows of one request leave in order without gaps in validity.
  `JTS_ASSERT_NEXT(a_row_step, out_o.valid && out_o.ready && !out_o.last_row, out_o.valid && (out_o.row_index == $past(out_o.row_index) + 3'd1), "row sequence broken")

  // A new request handed to the sequencer always starts at row 0.
  `JTS_ASSERT_NEXT(a_row_start, rows_take && sc_valid, out_o.valid && (out_o.row_index == jts_pkg::FIRST_ROW), "request did not start at first row")

  // A finished request waiting at the pipeline end keeps its results.
  `JTS_ASSERT_NEXT(a_pipe_hold, sc_valid && !rows_take, sc_valid && $stable(sc_cos) && $stable(sc_sin) && $stable(sc_pos), "stalled pipeline output changed")

endmodule

`default_nettype wire

// File: sv/jts_front.sv
// Front end: request register and joint type decode.
`default_nettype none

module jts_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  jts_in_if.sink                            in_i,
  input  wire logic                         full_i,
  output      logic                         push_o,
  output      jts_pkg::cls_t                cls_o,
  output      logic signed [DATA_WIDTH-1:0] pos_o
);

  logic                         vld_q;
  jts_pkg::cls_t                cls_q, cls_d;
  logic signed [DATA_WIDTH-1:0] pos_q;
  logic                         take;

  assign in_i.ready = !vld_q || !full_i;
  assign take       = in_i.valid && in_i.ready;
  assign push_o     = vld_q && !full_i;
  assign cls_o      = cls_q;
  assign pos_o      = pos_q;

  always_comb begin
    cls_d = '{revolute: 1'b0, axis: jts_pkg::AXIS_X, invalid: 1'b0};
    unique case (jts_pkg::jt_e'(in_i.joint_type)) inside
      jts_pkg::JT_PRISM_X: cls_d.axis = jts_pkg::AXIS_X;
      jts_pkg::JT_PRISM_Y: cls_d.axis = jts_pkg::AXIS_Y;
      jts_pkg::JT_PRISM_Z: cls_d.axis = jts_pkg::AXIS_Z;
      jts_pkg::JT_INVALID: begin
        cls_d.axis    = jts_pkg::AXIS_X;
        cls_d.invalid = 1'b1;
      end
      jts_pkg::JT_REV_X, jts_pkg::JT_REV_X_ALT: begin
        cls_d.revolute = 1'b1;
        cls_d.axis     = jts_pkg::AXIS_X;
      end
      jts_pkg::JT_REV_Y: begin
        cls_d.revolute = 1'b1;
        cls_d.axis     = jts_pkg::AXIS_Y;
      end
      jts_pkg::JT_REV_Z: begin
        cls_d.revolute = 1'b1;
        cls_d.axis     = jts_pkg::AXIS_Z;
      end
      default: cls_d.axis = jts_pkg::AXIS_X;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= cls_d;
      pos_q <= in_i.position;
    end
  end

endmodule

`default_nettype wire

// File: sv/jts_fifo.sv
// Small request queue between front end and arithmetic pipeline.
`default_nettype none

module jts_fifo #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] data_o,
  output      logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/jts_sincos.sv
// Angle reduction and pipelined CORDIC sine/cosine, with side data carried along.
`default_nettype none

module jts_sincos #(
  parameter int unsigned DATA_WIDTH        = 32,
  parameter int unsigned FRAC_BITS         = 16,
  parameter int unsigned CORDIC_ITERATIONS = 18
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         in_valid_i,
  input  wire jts_pkg::cls_t                in_cls_i,
  input  wire logic signed [DATA_WIDTH-1:0] in_pos_i,
  output      logic                         out_valid_o,
  output      jts_pkg::cls_t                out_cls_o,
  output      logic signed [DATA_WIDTH-1:0] out_pos_o,
  output      logic signed [DATA_WIDTH-1:0] cos_o,
  output      logic signed [DATA_WIDTH-1:0] sin_o,
  output      logic signed [DATA_WIDTH-1:0] nsin_o
);

  localparam int unsigned ZW  = jts_pkg::Q30_W;
  localparam int unsigned RW  = ((DATA_WIDTH > ZW) ? DATA_WIDTH : ZW) + 1;
  localparam int unsigned SH  = jts_pkg::Q30_FRAC - FRAC_BITS;
  localparam int unsigned NIT = (CORDIC_ITERATIONS > jts_pkg::ATAN_N) ?
                                jts_pkg::ATAN_N : CORDIC_ITERATIONS;

  // 2*pi in the input format, rounded to nearest
  localparam logic [63:0] TWOPI_F =
      (jts_pkg::TWOPI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);

  // number of shifted copies of 2*pi that fit below the largest magnitude
  function automatic int unsigned mod_steps(input logic [63:0] tf, input int unsigned dw);
    logic [64:0] lim;
    logic [64:0] stp;
    int unsigned n;
    lim = 65'd1 << (dw - 1);
    stp = {1'b0, tf};
    n   = 0;
    while (stp <= lim) begin
      n++;
      stp = stp << 1;
    end
    return n;
  endfunction

  localparam int unsigned MS = mod_steps(TWOPI_F, DATA_WIDTH);
  localparam int unsigned L  = MS + NIT + 6;

  // stage positions
  localparam int unsigned ST_CORR = MS + 1;

  localparam logic [RW-1:0]          TWOPI_R = RW'(TWOPI_F);
  localparam logic signed [ZW-1:0]   RHALF   = ZW'((64'd1 << SH) >> 1);

  // valid and side data line, one entry per stage
  logic [L-1:0]                 vld_q;
  jts_pkg::cls_t                cls_line_q [L];
  logic signed [DATA_WIDTH-1:0] pos_line_q [L];

  logic [RW-1:0]        mag_q [MS+1];
  logic signed [ZW-1:0] z0_q, z1_q;
  logic signed [ZW-1:0] cx_q [NIT+1];
  logic signed [ZW-1:0] cy_q [NIT+1];
  logic signed [ZW-1:0] cz_q [NIT+1];
  logic                 flip_q [NIT+2];
  logic signed [ZW-1:0] rx_q, ry_q;
  logic signed [DATA_WIDTH-1:0] cos_q, sin_q, nsin_q;

  logic signed [RW-1:0] pos_ext;
  logic [RW-1:0]        red;
  logic                 pos_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_line_q[0] <= in_cls_i;
      pos_line_q[0] <= in_pos_i;
      for (int j = 1; j < L; j++) begin
        cls_line_q[j] <= cls_line_q[j-1];
        pos_line_q[j] <= pos_line_q[j-1];
      end
    end
  end

  // stage 0: magnitude
  assign pos_ext = RW'(in_pos_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q[0] <= in_pos_i[DATA_WIDTH-1] ? RW'(-pos_ext) : RW'(pos_ext);
    end
  end

  // restoring reduction, one shifted 2*pi per stage, largest first
  for (genvar g = 0; g < MS; g++) begin : g_mod
    localparam logic [RW-1:0] STEP = RW'(TWOPI_F << (MS - 1 - g));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q[g+1] <= (mag_q[g] >= STEP) ? mag_q[g] - STEP : mag_q[g];
      end
    end
  end

  // floor modulo for negative angles, then move to Q30
  assign pos_neg = pos_line_q[ST_CORR-1][DATA_WIDTH-1];
  assign red     = (pos_neg && (mag_q[MS] != '0)) ? TWOPI_R - mag_q[MS] : mag_q[MS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q <= ZW'(red) << SH;
      z1_q <= (z0_q >= jts_pkg::PI30) ? z0_q - jts_pkg::TWOPI30 : z0_q;
      // fold into [-pi/2, pi/2]
      if (z1_q > jts_pkg::HALF30) begin
        cz_q[0]   <= z1_q - jts_pkg::PI30;
        flip_q[0] <= 1'b1;
      end else if (z1_q < -jts_pkg::HALF30) begin
        cz_q[0]   <= z1_q + jts_pkg::PI30;
        flip_q[0] <= 1'b1;
      end else begin
        cz_q[0]   <= z1_q;
        flip_q[0] <= 1'b0;
      end
      cx_q[0] <= jts_pkg::CORDIC_GAIN;
      cy_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cz_q[i][ZW-1]) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - jts_pkg::ATAN_Q30[i];
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + jts_pkg::ATAN_Q30[i];
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  // round half up to the output format, then undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q         <= (cx_q[NIT] + RHALF) >>> SH;
      ry_q         <= (cy_q[NIT] + RHALF) >>> SH;
      flip_q[NIT+1] <= flip_q[NIT];
      cos_q  <= DATA_WIDTH'(flip_q[NIT+1] ? -rx_q : rx_q);
      sin_q  <= DATA_WIDTH'(flip_q[NIT+1] ? -ry_q : ry_q);
      nsin_q <= DATA_WIDTH'(flip_q[NIT+1] ? ry_q : -ry_q);
    end
  end

  assign out_valid_o = vld_q[L-1];
  assign out_cls_o   = cls_line_q[L-1];
  assign out_pos_o   = pos_line_q[L-1];
  assign cos_o       = cos_q;
  assign sin_o       = sin_q;
  assign nsin_o      = nsin_q;

endmodule

`default_nettype wire

// File: sv/jts_rows.sv
// Row sequencer: holds one finished request and emits its six transform rows.
`default_nettype none

module jts_rows #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         take_o,
  input  wire jts_pkg::cls_t                in_cls_i,
  input  wire logic signed [DATA_WIDTH-1:0] in_pos_i,
  input  wire logic signed [DATA_WIDTH-1:0] cos_i,
  input  wire logic signed [DATA_WIDTH-1:0] sin_i,
  input  wire logic signed [DATA_WIDTH-1:0] nsin_i,
  jts_out_if.source                         out_o
);

  localparam logic signed [DATA_WIDTH-1:0] ONE  =
      {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic                         busy_q;
  logic [2:0]                   row_q;
  jts_pkg::cls_t                cls_q;
  logic signed [DATA_WIDTH-1:0] c_q, s_q, ns_q, pos_q, npos_q;
  logic signed [DATA_WIDTH-1:0] npos_d;

  logic signed [DATA_WIDTH-1:0] el [6];
  logic signed [DATA_WIDTH-1:0] e3 [3];
  logic signed [DATA_WIDTH-1:0] rv [3];
  logic signed [DATA_WIDTH-1:0] nrv [3];
  logic                         upper;
  logic [1:0]                   lr;
  logic                         load;

  assign take_o = !busy_q || (out_o.ready && (row_q == jts_pkg::LAST_ROW));
  assign load   = take_o && in_valid_i;
  // negating the most negative offset saturates to the largest positive value
  assign npos_d = (in_pos_i == MINV) ? MAXV : -in_pos_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= jts_pkg::FIRST_ROW;
    end else if (take_o) begin
      busy_q <= in_valid_i;
      row_q  <= jts_pkg::FIRST_ROW;
    end else if (out_o.ready) begin
      row_q <= row_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q  <= in_cls_i;
      pos_q  <= in_pos_i;
      npos_q <= npos_d;
      c_q    <= cos_i;
      s_q    <= sin_i;
      ns_q   <= nsin_i;
    end
  end

  assign upper = (row_q >= jts_pkg::ROW_RX);
  assign lr    = upper ? 2'(row_q - jts_pkg::ROW_RX) : row_q[1:0];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      el[k] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      e3[k]  = '0;
      rv[k]  = '0;
      nrv[k] = '0;
    end
    if (cls_q.revolute) begin
      case (cls_q.axis)
        jts_pkg::AXIS_Y: begin
          case (lr)
            2'd0: begin e3[0] = c_q; e3[2] = ns_q; end
            2'd1: e3[1] = ONE;
            default: begin e3[0] = s_q; e3[2] = c_q; end
          endcase
        end
        jts_pkg::AXIS_Z: begin
          case (lr)
            2'd0: begin e3[0] = c_q; e3[1] = s_q; end
            2'd1: begin e3[0] = ns_q; e3[1] = c_q; end
            default: e3[2] = ONE;
          endcase
        end
        default: begin
          case (lr)
            2'd0: e3[0] = ONE;
            2'd1: begin e3[1] = c_q; e3[2] = s_q; end
            default: begin e3[1] = ns_q; e3[2] = c_q; end
          endcase
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        if (upper) begin
          el[k+3] = e3[k];
        end else begin
          el[k] = e3[k];
        end
      end
    end else begin
      // offset vector has one nonzero component on the joint axis
      case (cls_q.axis)
        jts_pkg::AXIS_Y: begin rv[1] = pos_q; nrv[1] = npos_q; end
        jts_pkg::AXIS_Z: begin rv[2] = pos_q; nrv[2] = npos_q; end
        default:         begin rv[0] = pos_q; nrv[0] = npos_q; end
      endcase
      for (int k = 0; k < 6; k++) begin
        if (row_q == 3'(k)) begin
          el[k] = ONE;
        end
      end
      if (row_q == jts_pkg::ROW_RX) begin
        el[1] = rv[2];
        el[2] = nrv[1];
      end else if (row_q == jts_pkg::ROW_RY) begin
        el[0] = nrv[2];
        el[2] = rv[0];
      end else if (row_q == jts_pkg::ROW_RZ) begin
        el[0] = rv[1];
        el[1] = nrv[0];
      end
    end
  end

  assign out_o.valid     = busy_q;
  assign out_o.row_index = row_q;
  assign out_o.element_0 = el[0];
  assign out_o.element_1 = el[1];
  assign out_o.element_2 = el[2];
  assign out_o.element_3 = el[3];
  assign out_o.element_4 = el[4];
  assign out_o.element_5 = el[5];
  assign out_o.subspace_element = cls_q.revolute ?
      (row_q == {1'b0, cls_q.axis}) :
      (row_q == jts_pkg::ROW_RX + {1'b0, cls_q.axis});
  assign out_o.invalid_type = cls_q.invalid;
  assign out_o.last_row     = (row_q == jts_pkg::LAST_ROW);

endmodule

`default_nettype wire

// File: test/joint_transform_and_subspace_tb.sv
// Self-checking testbench for the spatial joint transform and motion subspace block.
module joint_transform_and_subspace_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW      = 32;
  localparam int unsigned FRAC    = 16;
  localparam int unsigned ITERS   = 18;
  localparam int unsigned RAND_N  = 246;
  // The tail wait covers the path from acceptance to row 0 with margin.
  localparam int unsigned TAIL_CYCLES = 80;
  localparam longint Q16_ONE   = 64'sd1 <<< FRAC;
  localparam longint POS_MAX   = 64'sd2147483647;
  localparam longint POS_MIN   = -64'sd2147483648;
  // Angles in Q16.16 radians.
  localparam int HALF_PI_Q16   = 102944;
  localparam int PI_Q16        = 205887;
  localparam int TWO_PI_Q16    = 411775;

  // One request queued for the sender: drain_first makes the sender hold it
  // back until every outstanding row has come out.
  typedef struct {
    jts_pkg::jt_e          kind;
    logic signed [DW-1:0]  pos;
    bit                    drain_first;
  } joint_req_t;

  // One expected row of XJ plus its subspace entry and flags.
  typedef struct packed {
    logic [2:0]          row;
    logic [5:0][DW-1:0]  col;
    logic                sub;
    logic                bad_type;
    logic                last;
  } xj_row_t;

  logic clk_i;
  logic rst_ni;

  jts_in_if  #(.DATA_WIDTH(DW)) req_if ();
  jts_out_if #(.DATA_WIDTH(DW)) row_if ();

  joint_transform_and_subspace #(
    .DATA_WIDTH       (DW),
    .FRAC_BITS        (FRAC),
    .CORDIC_ITERATIONS(ITERS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (row_if)
  );

  joint_req_t pending[$];     // requests not yet offered
  joint_req_t in_flight;      // request currently on the input channel
  xj_row_t    rows_due[$];    // predicted rows, oldest first
  int         n_accepted;     // requests taken by the block
  int         n_errors = 0;
  int         hold_left;      // cycles left in the long output stall
  bit         hold_used;

  // No random idling on either side while this window of requests goes in.
  wire steady = (n_accepted >= 150) && (n_accepted < 200);

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Reset: held low from time zero, released once on a falling clock edge.
  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("joint_transform_and_subspace_tb: errors");
    $finish;
  end

  task automatic note_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Negating the most negative offset saturates to the largest positive value.
  function automatic longint neg_sat(input longint v);
    return (v == POS_MIN) ? POS_MAX : -v;
  endfunction

  // Sine and cosine of a Q16.16 angle: reduce modulo 2*pi (floored), move to
  // Q30, fold into [-pi/2, pi/2], run the rotation-mode CORDIC, round back.
  task automatic cordic_sincos(input longint angle, output longint cos_q,
                               output longint sin_q);
    longint twopi_f, a, x, y, z, dx, dy, step;
    bit     flip;
    twopi_f = longint'((jts_pkg::TWOPI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
    a = angle % twopi_f;   // truncates toward zero, then lift to [0, 2pi)
    if (a < 0)
      a += twopi_f;
    z    = a * (64'sd1 <<< (jts_pkg::Q30_FRAC - FRAC));
    flip = 1'b0;
    if (z >= longint'(jts_pkg::PI30))
      z -= longint'(jts_pkg::TWOPI30);
    if (z > longint'(jts_pkg::HALF30)) begin
      z -= longint'(jts_pkg::PI30);
      flip = 1'b1;
    end else if (z < -longint'(jts_pkg::HALF30)) begin
      z += longint'(jts_pkg::PI30);
      flip = 1'b1;
    end
    x = longint'(jts_pkg::CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < ITERS && i < jts_pkg::ATAN_N; i++) begin
      dx   = y >>> i;
      dy   = x >>> i;
      step = longint'(jts_pkg::ATAN_Q30[i]);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= step;
      end else begin
        x += dx;
        y -= dy;
        z += step;
      end
    end
    // Round half up from Q30 to the output fraction.
    x = (x + (64'sd1 <<< (jts_pkg::Q30_FRAC - FRAC - 1))) >>> (jts_pkg::Q30_FRAC - FRAC);
    y = (y + (64'sd1 <<< (jts_pkg::Q30_FRAC - FRAC - 1))) >>> (jts_pkg::Q30_FRAC - FRAC);
    cos_q = flip ? -x : x;
    sin_q = flip ? -y : y;
  endtask

  // Builds XJ and S for one request and queues its six rows.
  task automatic predict_rows(input joint_req_t req);
    longint  m[6][6];
    longint  e[3][3];
    longint  rv[3];
    longint  c, s, q;
    int      sub_row, axis;
    xj_row_t r;
    q = longint'(req.pos);
    for (int i = 0; i < 6; i++)
      for (int k = 0; k < 6; k++)
        m[i][k] = 0;
    if (req.kind inside {jts_pkg::JT_REV_X, jts_pkg::JT_REV_Y, jts_pkg::JT_REV_Z,
                         jts_pkg::JT_REV_X_ALT}) begin
      cordic_sincos(q, c, s);
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          e[i][k] = 0;
      case (req.kind)
        jts_pkg::JT_REV_Z: begin
          e[0][0] = c;  e[0][1] = s;  e[1][0] = -s;  e[1][1] = c;
          e[2][2] = Q16_ONE;
          sub_row = 2;
        end
        jts_pkg::JT_REV_Y: begin
          e[0][0] = c;  e[0][2] = -s;  e[1][1] = Q16_ONE;
          e[2][0] = s;  e[2][2] = c;
          sub_row = 1;
        end
        default: begin
          // revolute x, and the alternate code that acts as revolute x
          e[0][0] = Q16_ONE;  e[1][1] = c;  e[1][2] = s;
          e[2][1] = -s;       e[2][2] = c;
          sub_row = 0;
        end
      endcase
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) begin
          m[i][k]         = e[i][k];
          m[i + 3][k + 3] = e[i][k];
        end
    end else begin
      // Prismatic; the invalid code behaves as prismatic x.
      axis     = (req.kind == jts_pkg::JT_PRISM_Z) ? 2 :
                 (req.kind == jts_pkg::JT_PRISM_Y) ? 1 : 0;
      rv       = '{0, 0, 0};
      rv[axis] = q;
      sub_row  = 3 + axis;
      for (int i = 0; i < 6; i++)
        m[i][i] = Q16_ONE;
      m[3][1] = rv[2];          m[3][2] = neg_sat(rv[1]);
      m[4][0] = neg_sat(rv[2]); m[4][2] = rv[0];
      m[5][0] = rv[1];          m[5][1] = neg_sat(rv[0]);
    end
    for (int i = 0; i < 6; i++) begin
      r.row = 3'(i);
      for (int k = 0; k < 6; k++)
        r.col[k] = m[i][k][DW-1:0];
      r.sub      = (i == sub_row);
      r.bad_type = (req.kind == jts_pkg::JT_INVALID);
      r.last     = (i == 5);
      rows_due.insert(rows_due.size(), r);
    end
  endtask

  // Sender: a request held against a low ready stays put; otherwise the next
  // one goes out unless the sender idles or must wait for the pipe to drain.
  always @(posedge clk_i or negedge rst_ni) begin
    bit rest;
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.joint_type <= jts_pkg::JT_PRISM_X;
      req_if.position   <= '0;
      n_accepted        <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_rows(in_flight);
        n_accepted <= n_accepted + 1;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        rest = ($urandom_range(0, 99) < 27) && !steady;
        if (pending.size() != 0 && !rest &&
            !(pending[0].drain_first && rows_due.size() != 0)) begin
          in_flight          = pending.pop_front();
          req_if.valid      <= 1'b1;
          req_if.joint_type <= in_flight.kind;
          req_if.position   <= in_flight.pos;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long output stall, started once after 80 requests, so the block fills
  // up and pushes back on its input while the sender keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && n_accepted == 80) begin
      hold_left <= 300;
      hold_used <= 1'b1;
    end
  end

  // Receiver: checks each taken row against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    xj_row_t            want;
    logic [5:0][DW-1:0] got_col;
    if (!rst_ni) begin
      row_if.ready <= 1'b0;
    end else begin
      if (row_if.valid && row_if.ready) begin
        if (rows_due.size() == 0) begin
          note_mismatch("row with no request outstanding", row_if.row_index, -1);
        end else begin
          want    = rows_due.pop_front();
          got_col = {row_if.element_5, row_if.element_4, row_if.element_3,
                     row_if.element_2, row_if.element_1, row_if.element_0};
          if (row_if.row_index !== want.row)
            note_mismatch("row_index", row_if.row_index, want.row);
          for (int k = 0; k < 6; k++)
            if (got_col[k] !== want.col[k])
              note_mismatch($sformatf("row %0d element_%0d", want.row, k),
                            longint'($signed(got_col[k])), longint'($signed(want.col[k])));
          if (row_if.subspace_element !== want.sub)
            note_mismatch($sformatf("row %0d subspace_element", want.row),
                          row_if.subspace_element, want.sub);
          if (row_if.invalid_type !== want.bad_type)
            note_mismatch($sformatf("row %0d invalid_type", want.row),
                          row_if.invalid_type, want.bad_type);
          if (row_if.last_row !== want.last)
            note_mismatch($sformatf("row %0d last_row", want.row),
                          row_if.last_row, want.last);
        end
      end
      row_if.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 27);
    end
  end

  function automatic joint_req_t mk_req(input jts_pkg::jt_e kind, input longint pos,
                                        input bit drain_first = 1'b0);
    joint_req_t r;
    r.kind        = kind;
    r.pos         = pos[DW-1:0];
    r.drain_first = drain_first;
    return r;
  endfunction

  // Appends one request to the sender's list.
  function automatic void add_req(input jts_pkg::jt_e kind, input longint pos);
    pending.insert(pending.size(), mk_req(kind, pos));
  endfunction

  // Stimulus and end of run.
  initial begin
    joint_req_t r;

    // Directed: every joint code at zero, offset extremes (saturating
    // negation included), the invalid code, the fold boundaries of the angle.
    add_req(jts_pkg::JT_PRISM_X,   0);
    add_req(jts_pkg::JT_PRISM_Y,   0);
    add_req(jts_pkg::JT_PRISM_Z,   0);
    add_req(jts_pkg::JT_INVALID,   0);
    add_req(jts_pkg::JT_REV_X,     0);
    add_req(jts_pkg::JT_REV_Y,     0);
    add_req(jts_pkg::JT_REV_Z,     0);
    add_req(jts_pkg::JT_REV_X_ALT, 0);
    add_req(jts_pkg::JT_PRISM_X,   POS_MIN);
    add_req(jts_pkg::JT_PRISM_Y,   POS_MIN);
    add_req(jts_pkg::JT_PRISM_Z,   POS_MIN);
    add_req(jts_pkg::JT_INVALID,   POS_MAX);
    add_req(jts_pkg::JT_PRISM_Y,   POS_MAX);
    add_req(jts_pkg::JT_PRISM_Z,   -1);
    add_req(jts_pkg::JT_REV_X,     HALF_PI_Q16);
    add_req(jts_pkg::JT_REV_Y,     PI_Q16);
    add_req(jts_pkg::JT_REV_Z,     -PI_Q16);
    add_req(jts_pkg::JT_REV_X_ALT, TWO_PI_Q16);
    add_req(jts_pkg::JT_REV_Y,     POS_MAX);
    add_req(jts_pkg::JT_REV_Z,     POS_MIN);
    add_req(jts_pkg::JT_REV_X,     -1);
    add_req(jts_pkg::JT_REV_Y,     3 * HALF_PI_Q16);
    add_req(jts_pkg::JT_REV_Z,     -HALF_PI_Q16 - 1);
    add_req(jts_pkg::JT_INVALID,   -HALF_PI_Q16);

    // Random: any code; angles mostly within +-4*pi, the rest full range.
    for (int i = 0; i < RAND_N; i++) begin
      r.kind = jts_pkg::jt_e'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 60)
        r.pos = DW'(int'($urandom_range(0, 8 * TWO_PI_Q16 / 2)) - 2 * TWO_PI_Q16);
      else
        r.pos = $urandom;
      // sender waits for a full drain after the directed part and once later
      r.drain_first = (i == 0) || (i == 180);
      pending.insert(pending.size(), r);
    end

    @(posedge clk_i);
    while (rst_ni !== 1'b1)
      @(posedge clk_i);
    while (pending.size() != 0 || req_if.valid)
      @(posedge clk_i);
    while (rows_due.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (n_errors == 0)
      $display("joint_transform_and_subspace_tb: clean");
    else
      $display("joint_transform_and_subspace_tb: errors");
    $finish;
  end

endmodule

// File: joint_transform_and_subspace.f
+incdir+sv
sv/jts_pkg.sv
sv/jts_if.sv
sv/jts_front.sv
sv/jts_fifo.sv
sv/jts_sincos.sv
sv/jts_rows.sv
sv/joint_transform_and_subspace.sv
test/joint_transform_and_subspace_tb.sv
